FILE: rtl/elx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elx_pkg
// Shared types and constants of the expression lexer: token kinds, error
// codes, lexer modes, token and bundle records, character constants.
// ----------------------------------------------------------------------------
package elx_pkg;

	localparam int unsigned MAX_TEXT_BYTES_DEF = 4096;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

	typedef enum logic [4:0] {
		K_AND   = 5'd0,
		K_OR    = 5'd1,
		K_EQ    = 5'd2,
		K_NE    = 5'd3,
		K_NOT   = 5'd4,
		K_LT    = 5'd5,
		K_LE    = 5'd6,
		K_GT    = 5'd7,
		K_GE    = 5'd8,
		K_ADD   = 5'd9,
		K_SUB   = 5'd10,
		K_MUL   = 5'd11,
		K_DIV   = 5'd12,
		K_POW   = 5'd13,
		K_OPEN  = 5'd14,
		K_CLOSE = 5'd15,
		K_COMMA = 5'd16,
		K_NUM   = 5'd17,
		K_IDENT = 5'd18,
		K_ERROR = 5'd19
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_CHAR    = 2'd1,
		ERR_POINT   = 2'd2,
		ERR_TOOLONG = 2'd3
	} err_t;

	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_BANG    = 4'd1,
		M_LT      = 4'd2,
		M_GT      = 4'd3,
		M_INT     = 4'd4,
		M_PTNEED  = 4'd5,
		M_FRAC    = 4'd6,
		M_EXP     = 4'd7,
		M_EXPSIGN = 4'd8,
		M_EXPDIG  = 4'd9,
		M_IDENT   = 4'd10,
		M_IGNORE  = 4'd11
	} mode_t;

	// packed so that kind lands in the low bits of the output beat
	typedef struct packed {
		err_t        err;
		logic [12:0] length;
		logic [11:0] start;
		kind_t       kind;
	} tok_t;

	// all results caused by one input byte
	typedef struct packed {
		logic    two;
		tok_t    tok1;
		tok_t    tok0;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LESS   = 8'h3C;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_MORE   = 8'h3E;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_E_LO   = 8'h65;
	localparam logic [7:0] CH_E_UP   = 8'h45;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
			|| (c == CH_UNDER);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/expression_lexer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// expression_lexer_unit
// Streaming tokenizer for arithmetic expressions: bytes in, tokens out.
// ----------------------------------------------------------------------------
// Path: the byte that finishes a token writes its bundle into the queue, and
// the token then leaves through the output register.
// Throughput: one byte per cycle while the queue is not full; the output register
// moves one token per cycle while m_tready is high, so two-token bytes drain
// slower, and the four-bundle queue between lexer and output stage absorbs that.
// Reset: arst_n clears the lexer mode, byte position, queue and output valid.
module expression_lexer_unit #(
	parameter int unsigned MAX_TEXT_BYTES = elx_pkg::MAX_TEXT_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] char_code
	input  wire logic         s_tlast,   // end_of_text
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [31:0]       m_tdata,   // [4:0] token_kind, [16:5] token_start,
	                                     // [29:17] token_length, [31:30] error_code
	output logic              m_tlast    // last_of_run
);
	import elx_pkg::*;

	logic     push;
	bundle_t  push_data;
	bundle_t  head;
	qstat_t   stat;
	logic     pop;
	tok_t     out_tok;

	assign s_tready = !stat.full;

	elx_front #(
		.MAX_TEXT_BYTES(MAX_TEXT_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_char   (s_tdata),
		.in_end    (s_tlast),
		.space_ok  (s_tready),
		.push      (push),
		.push_data (push_data)
	);

	elx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	elx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (out_tok),
		.out_last  (m_tlast)
	);

	assign m_tdata = out_tok;

endmodule
`default_nettype wire

FILE: rtl/elx_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elx_front
// Lexer mode machine: takes one byte per beat and builds the bundle of up to
// two tokens that the byte finishes.
// ----------------------------------------------------------------------------
module elx_front #(
	parameter int unsigned MAX_TEXT_BYTES = elx_pkg::MAX_TEXT_BYTES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [7:0]      in_char,
	input  wire logic            in_end,
	input  wire logic            space_ok,
	output logic                 push,
	output elx_pkg::bundle_t     push_data
);
	import elx_pkg::*;

	localparam int unsigned PosW = $clog2(MAX_TEXT_BYTES + 1);
	localparam int unsigned DiffW = (PosW > 13) ? PosW : 13;
	localparam logic [PosW-1:0] MaxPos = PosW'(MAX_TEXT_BYTES);
	localparam logic [12:0] MaxLen = 13'(MAX_TEXT_BYTES);

	typedef struct packed {
		logic  hit;
		tok_t  tok;
		mode_t nxt;
	} step_t;

	mode_t            mode_q, mode_d;
	logic [PosW-1:0]  tbeg_q, tbeg_d;
	logic [PosW-1:0]  pos_q, pos_d;
	tok_t             tk [2];
	logic [1:0]       n;
	logic             accept;

	function automatic tok_t mk_tok(kind_t k, logic [PosW-1:0] b, logic [12:0] len, err_t e);
		tok_t t;
		logic [DiffW-1:0] bx;
		bx = DiffW'(b);
		t.kind = k;
		t.start = bx[11:0];
		t.length = len;
		t.err = e;
		return t;
	endfunction

	// ends the pending token at position e (exclusive)
	function automatic step_t do_flush(mode_t m, logic [PosW-1:0] b, logic [PosW-1:0] e);
		step_t r;
		logic [DiffW-1:0] d;
		d = DiffW'(e) - DiffW'(b);
		r.hit = 1'b1;
		r.nxt = M_IDLE;
		r.tok = mk_tok(K_NUM, b, d[12:0], ERR_NONE);
		unique case (m)
			M_BANG: r.tok.kind = K_NOT;
			M_LT: r.tok.kind = K_LT;
			M_GT: r.tok.kind = K_GT;
			M_INT, M_FRAC, M_EXP, M_EXPSIGN, M_EXPDIG: r.tok.kind = K_NUM;
			M_IDENT: r.tok.kind = K_IDENT;
			M_PTNEED: begin
				r.tok.kind = K_ERROR;
				r.tok.err = ERR_POINT;
				r.nxt = M_IGNORE;
			end
			M_IGNORE: begin
				r.hit = 1'b0;
				r.nxt = M_IGNORE;
			end
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// byte that opens a new token; nxt tells the pending mode
	function automatic step_t do_start(logic [7:0] c, logic [PosW-1:0] p);
		step_t r;
		r.hit = 1'b1;
		r.nxt = M_IDLE;
		r.tok = mk_tok(K_ADD, p, 13'd1, ERR_NONE);
		unique case (c)
			CH_AMP: r.tok.kind = K_AND;
			CH_PIPE: r.tok.kind = K_OR;
			CH_EQUAL: r.tok.kind = K_EQ;
			CH_PLUS: r.tok.kind = K_ADD;
			CH_MINUS: r.tok.kind = K_SUB;
			CH_STAR: r.tok.kind = K_MUL;
			CH_SLASH: r.tok.kind = K_DIV;
			CH_CARET: r.tok.kind = K_POW;
			CH_LPAREN: r.tok.kind = K_OPEN;
			CH_RPAREN: r.tok.kind = K_CLOSE;
			CH_COMMA: r.tok.kind = K_COMMA;
			CH_BANG: begin r.hit = 1'b0; r.nxt = M_BANG; end
			CH_LESS: begin r.hit = 1'b0; r.nxt = M_LT; end
			CH_MORE: begin r.hit = 1'b0; r.nxt = M_GT; end
			CH_POINT: begin r.hit = 1'b0; r.nxt = M_PTNEED; end
			CH_TAB, CH_LF, CH_CR, CH_SPACE: r.hit = 1'b0;
			default: begin
				if (is_digit(c)) begin
					r.hit = 1'b0;
					r.nxt = M_INT;
				end else if (is_alpha(c)) begin
					r.hit = 1'b0;
					r.nxt = M_IDENT;
				end else begin
					r.tok.kind = K_ERROR;
					r.tok.err = ERR_CHAR;
					r.nxt = M_IGNORE;
				end
			end
		endcase
		return r;
	endfunction

	assign accept = in_valid && space_ok;

	always_comb begin
		step_t  fl;
		step_t  st;
		logic   eat;
		logic   is_e;
		mode_d = mode_q;
		tbeg_d = tbeg_q;
		pos_d = pos_q;
		n = 2'd0;
		tk[0] = mk_tok(K_ERROR, tbeg_q, MaxLen, ERR_TOOLONG);
		tk[1] = tk[0];
		eat = 1'b0;
		is_e = (in_char == CH_E_LO) || (in_char == CH_E_UP);
		fl = do_flush(mode_q, tbeg_q, pos_q);
		st = do_start(in_char, pos_q);
		if (mode_q != M_IGNORE) begin
			if (in_char == CH_NUL) begin
				if (fl.hit) begin tk[0] = fl.tok; n = 2'd1; end
				mode_d = M_IGNORE;
			end else if (pos_q >= MaxPos) begin
				if (fl.hit) begin tk[0] = fl.tok; n = 2'd1; end
				if (fl.nxt != M_IGNORE) begin
					tk[n[0]] = mk_tok(K_ERROR, '0, MaxLen, ERR_TOOLONG);
					n = n + 2'd1;
				end
				mode_d = M_IGNORE;
			end else begin
				// feed: stay inside the pending token where the byte extends it
				unique case (mode_q)
					M_BANG, M_LT, M_GT: begin
						if (in_char == CH_EQUAL) begin
							eat = 1'b1;
							mode_d = M_IDLE;
							tk[0] = mk_tok((mode_q == M_BANG) ? K_NE :
								((mode_q == M_LT) ? K_LE : K_GE), tbeg_q, 13'd2, ERR_NONE);
							n = 2'd1;
						end
					end
					M_INT: begin
						if (is_digit(in_char)) eat = 1'b1;
						else if (in_char == CH_POINT) begin eat = 1'b1; mode_d = M_PTNEED; end
						else if (is_e) begin eat = 1'b1; mode_d = M_EXP; end
					end
					M_PTNEED: begin
						eat = 1'b1;
						if (is_digit(in_char)) mode_d = M_FRAC;
						else begin
							tk[0] = fl.tok;
							n = 2'd1;
							mode_d = fl.nxt;
						end
					end
					M_FRAC: begin
						if (is_digit(in_char)) eat = 1'b1;
						else if (is_e) begin eat = 1'b1; mode_d = M_EXP; end
					end
					M_EXP: begin
						if (in_char == CH_PLUS || in_char == CH_MINUS) begin
							eat = 1'b1;
							mode_d = M_EXPSIGN;
						end else if (is_digit(in_char)) begin
							eat = 1'b1;
							mode_d = M_EXPDIG;
						end
					end
					M_EXPSIGN, M_EXPDIG: begin
						if (is_digit(in_char)) begin eat = 1'b1; mode_d = M_EXPDIG; end
					end
					M_IDENT: begin
						if (is_alpha(in_char) || is_digit(in_char)) eat = 1'b1;
					end
					default: ;
				endcase
				if (!eat) begin
					if (fl.hit) begin tk[0] = fl.tok; n = 2'd1; end
					mode_d = st.nxt;
					tbeg_d = pos_q;
					if (st.hit) begin
						tk[n[0]] = st.tok;
						n = n + 2'd1;
					end
				end
				pos_d = pos_q + 1'b1;
				if (in_end && mode_d != M_IGNORE) begin
					fl = do_flush(mode_d, tbeg_d, pos_d);
					if (fl.hit) begin
						tk[n[0]] = fl.tok;
						n = n + 2'd1;
					end
				end
			end
		end
		if (in_end) begin
			mode_d = M_IDLE;
			tbeg_d = '0;
			pos_d = '0;
		end
	end

	assign push = accept && (n != 2'd0);
	assign push_data.tok0 = tk[0];
	assign push_data.tok1 = tk[1];
	assign push_data.two = n[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			tbeg_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			tbeg_q <= tbeg_d;
			pos_q <= pos_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/elx_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elx_queue
// Small FIFO of token bundles between the lexer and the output stage.
// ----------------------------------------------------------------------------
module elx_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire elx_pkg::bundle_t  push_data,
	input  wire logic              pop,
	output elx_pkg::bundle_t       head,
	output elx_pkg::qstat_t        stat
);
	import elx_pkg::*;

	bundle_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_q, rd_q;
	logic [QUEUE_AW:0]     cnt_q;

	assign stat.full = (cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full || pop)
		else $error("bundle pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("bundle popped from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
		else $error("queue count out of range");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not follow a push");

endmodule
`default_nettype wire

FILE: rtl/elx_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elx_back
// Output stage: walks through each queued bundle and puts one token per beat
// into the output register, marking the final token of each byte.
// ----------------------------------------------------------------------------
module elx_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire elx_pkg::bundle_t  head,
	input  wire elx_pkg::qstat_t   stat,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output elx_pkg::tok_t          out_tok,
	output logic                   out_last
);
	import elx_pkg::*;

	logic  valid_q;
	logic  sel_q;
	tok_t  tok_q;
	logic  last_q;
	logic  load;
	logic  take;
	logic  final_tok;

	assign load = !valid_q || out_ready;
	assign take = load && !stat.empty;
	assign final_tok = sel_q || !head.two;
	assign pop = take && final_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (load) begin
			valid_q <= !stat.empty;
			if (take) sel_q <= !final_tok;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_q <= sel_q ? head.tok1 : head.tok0;
			last_q <= final_tok;
		end
	end

	assign out_valid = valid_q;
	assign out_tok = tok_q;
	assign out_last = last_q;

	a_sel_has_second: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> !stat.empty && head.two)
		else $error("second token selected without a two-token bundle");
	a_sel_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(sel_q && take) |=> !sel_q)
		else $error("token select did not return after second token");
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ((tok_q.kind == K_ERROR) == (tok_q.err != ERR_NONE)))
		else $error("error code does not match token kind");

endmodule
`default_nettype wire
